// ===== rtl/core/mqf_pkg.sv =====
// Shared types and constants of the message queue pool.
// No dependencies; used by the channel interfaces, the store and the top level.
`timescale 1ns / 1ps

package mqf_pkg;

	localparam int ID_W       = 3;
	localparam int DATA_W     = 64;
	localparam int LEN_W      = 16;
	localparam int ISZ_W      = 10;
	localparam int WORDS_W    = 7;
	localparam int ITEM_LIMIT = 512;
	localparam int MAX_SLOTS  = 8;

	typedef enum logic [2:0] {
		CMD_CREATE = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_SEND   = 3'd2,
		CMD_RECV   = 3'd3,
		CMD_PEEK   = 3'd4,
		CMD_RESET  = 3'd5,
		CMD_QUERY  = 3'd6,
		CMD_CLEAR  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SEND_FAIL = 2'd1,
		ST_READ_FAIL = 2'd2,
		ST_FAIL      = 2'd3
	} status_t;

	// per-slot bookkeeping held in the descriptor memory
	typedef struct packed {
		logic [ISZ_W-1:0] item_bytes;
		logic [LEN_W-1:0] qlen;
		logic [LEN_W-1:0] count;
		logic [LEN_W-1:0] rpos;
		logic [LEN_W-1:0] wpos;
	} meta_t;

endpackage

// ===== rtl/core/mqf_req_if.sv =====
// Command channel of the message queue pool: valid/ready plus the command fields.
// Depends on mqf_pkg.
`timescale 1ns / 1ps

interface mqf_req_if;
	import mqf_pkg::*;

	logic                valid;
	logic                ready;
	cmd_t                cmd;
	logic [ID_W-1:0]     queue_id;
	logic [DATA_W-1:0]   data_word;
	logic                skip_data;
	logic [LEN_W-1:0]    length_req;
	logic [ISZ_W-1:0]    item_bytes_req;

	modport source (output valid, cmd, queue_id, data_word, skip_data, length_req,
		item_bytes_req, input ready);
	modport sink (input valid, cmd, queue_id, data_word, skip_data, length_req,
		item_bytes_req, output ready);
endinterface

// ===== rtl/core/mqf_rsp_if.sv =====
// Result channel of the message queue pool: valid/ready plus the result fields.
// Depends on mqf_pkg.
`timescale 1ns / 1ps

interface mqf_rsp_if;
	import mqf_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [ID_W-1:0]     handle_out;
	logic [LEN_W-1:0]    items_waiting;
	logic [LEN_W-1:0]    spaces_free;
	logic [DATA_W-1:0]   data_out;
	logic                last;

	modport source (output valid, status, handle_out, items_waiting, spaces_free,
		data_out, last, input ready);
	modport sink (input valid, status, handle_out, items_waiting, spaces_free,
		data_out, last, output ready);
endinterface

// ===== rtl/core/mqf_store.sv =====
// Byte store of the queue pool: eight byte-wide banks, one 64-bit word at any
// byte address per cycle, write with byte enables, registered read. Uses mqf_pkg.
`timescale 1ns / 1ps

module mqf_store #(
	parameter int BYTES  = 4096,
	parameter int ADDR_W = 13
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [mqf_pkg::DATA_W-1:0] wr_data,
	input  logic [7:0]                wr_mask,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [mqf_pkg::DATA_W-1:0] rd_data
);
	import mqf_pkg::*;

	localparam int ROWS  = BYTES / 8 + 2;
	localparam int ROW_W = $clog2(ROWS);

	logic [2:0]         wa0, ra0, ra0_q;
	logic [ADDR_W-4:0]  wrow, rrow;
	logic [7:0]         bank_q [8];

	assign wa0  = wr_addr[2:0];
	assign ra0  = rd_addr[2:0];
	assign wrow = wr_addr[ADDR_W-1:3];
	assign rrow = rd_addr[ADDR_W-1:3];

	// bank b holds item byte (b - a0) mod 8; banks below a0 sit one row up
	for (genvar b = 0; b < 8; b++) begin : g_bank
		logic [7:0]       mem [ROWS];
		logic [2:0]       wk;
		logic [ROW_W-1:0] wr_row_b, rd_row_b;

		assign wk       = 3'(b) - wa0;
		assign wr_row_b = ROW_W'(wrow + ((3'(b) < wa0) ? 1'b1 : 1'b0));
		assign rd_row_b = ROW_W'(rrow + ((3'(b) < ra0) ? 1'b1 : 1'b0));

		always_ff @(posedge clk) begin
			if (wr_en && wr_mask[wk])
				mem[wr_row_b] <= wr_data[8*wk +: 8];
			if (rd_en)
				bank_q[b] <= mem[rd_row_b];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			ra0_q <= ra0;
	end

	// rotate back into item byte order
	always_comb begin
		for (int k = 0; k < 8; k++)
			rd_data[8*k +: 8] = bank_q[3'(k) + ra0_q];
	end

endmodule

// ===== rtl/core/multi_queue_message_fifo.sv =====
// Top level of the message queue pool: command sequencer, descriptor memory.
// Depends on mqf_pkg, mqf_req_if, mqf_rsp_if and mqf_store.
`timescale 1ns / 1ps

// Usage
// req carries one command per transfer (create, delete, send word, receive,
// peek, reset, query, clear pool); rsp returns the results, last marking the
// final result of one command. Commands are handled one at a time.
// A result reaches the output register by way of the descriptor memory read at
// the transfer, the address multiply and the execute step. The sequencer then
// takes the next command while the result still waits in the output register.
// Receive and peek return one word at a time (byte store read plus result
// stage); the next word is read only after the previous one has been emitted.
// Create and delete then sweep the slot's store region and clear pool sweeps
// the whole store, one row write per cycle.
// Reset frees every slot and closes any open send; the byte store is not
// cleared, a created queue region is zeroed by its create sweep.
// A stalled rsp holds the result and the sequencer waits before the next one.
module multi_queue_message_fifo #(
	parameter int NUM_QUEUES  = 8,
	parameter int STORE_BYTES = 512,
	parameter int MAX_LENGTH  = 65535
) (
	input  logic      clk,
	input  logic      arst_n,
	mqf_req_if.sink   req,
	mqf_rsp_if.source rsp
);
	import mqf_pkg::*;

	localparam int TOTAL = NUM_QUEUES * STORE_BYTES;
	localparam int BA_W  = $clog2(TOTAL + 16);
	localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int SCAN  = (NUM_QUEUES < MAX_SLOTS) ? NUM_QUEUES : MAX_SLOTS;
	localparam int PROD_W = LEN_W + ISZ_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEC  = 6'b000010,
		S_EXEC = 6'b000100,
		S_RD   = 6'b001000,
		S_RDW  = 6'b010000,
		S_CLR  = 6'b100000
	} state_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   handle;
		logic [LEN_W-1:0]  waiting;
		logic [LEN_W-1:0]  free;
		logic [DATA_W-1:0] data;
		logic              last;
	} result_t;

	function automatic logic [7:0] byte_mask(input logic [WORDS_W-1:0] j,
		input logic [ISZ_W-1:0] isz);
		logic [7:0] m;
		for (int k = 0; k < 8; k++)
			m[k] = ({j, 3'b000} + (WORDS_W+3)'(k)) < (WORDS_W+3)'(isz);
		return m;
	endfunction

	state_t state_q, state_d;

	// latched command
	cmd_t              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [DATA_W-1:0] data_q;
	logic              skip_q;
	logic [LEN_W-1:0]  len_q;
	logic [ISZ_W-1:0]  isz_q;

	// descriptor memory and slot occupancy
	meta_t             meta_mem [NUM_QUEUES];
	meta_t             meta_rd;
	meta_t             meta_q;
	logic              meta_we;
	logic [QW-1:0]     meta_wa;
	meta_t             meta_wd;
	logic [NUM_QUEUES-1:0] used_q, used_d;

	// open send
	logic               send_active_q, send_active_d;
	logic               send_dropping_q, send_dropping_d;
	logic [ID_W-1:0]    send_queue_q, send_queue_d;
	logic [WORDS_W-1:0] send_words_left_q, send_words_left_d;

	// address stage, read loop, clearing sweep
	logic [PROD_W-1:0]  prod_q;
	logic [BA_W-1:0]    rd_base_q, rd_base_d;
	logic [WORDS_W-1:0] rd_j_q, rd_j_d;
	logic [BA_W-1:0]    clr_addr_q, clr_addr_d, clr_hi_q, clr_hi_d, clr_lo_q, clr_lo_d;

	// result register
	result_t out_q, res_d;
	logic    out_valid_q, emit, out_free;

	// store port
	logic              st_we, st_re;
	logic [BA_W-1:0]   st_waddr, st_raddr;
	logic [DATA_W-1:0] st_wdata, st_rdata;
	logic [7:0]        st_mask;

	// decode helpers
	logic [QW+2:0]      id_ext;
	logic [QW-1:0]      id_idx;
	logic               slot_ok;
	logic               keep, act, drp;
	logic [WORDS_W-1:0] words, left_e, wr_j;
	logic               full;
	logic [BA_W-1:0]    base;
	logic [LEN_W-1:0]   wpos_nx, rpos_nx;
	logic [2:0]         new_slot;
	logic               free_any, create_bad;
	logic [BA_W-1:0]    new_base, id_base;
	logic [7:0]         clr_mask;
	logic [7:0]         rd_mask;
	logic [LEN_W-1:0]   mul_a;
	logic [ISZ_W-1:0]   mul_b;

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	assign id_ext  = (QW+3)'(id_q);
	assign id_idx  = id_ext[QW-1:0];
	assign slot_ok = (id_ext < (QW+3)'(NUM_QUEUES)) && used_q[id_idx];

	assign words   = (meta_q.item_bytes == '0) ? WORDS_W'(1)
		: WORDS_W'((ISZ_W+1)'(meta_q.item_bytes) + (ISZ_W+1)'(7) >> 3);
	assign full    = meta_q.count >= meta_q.qlen;
	assign keep    = (cmd_q == CMD_SEND) && (send_queue_q == id_q);
	assign act     = send_active_q && keep;
	assign drp     = send_dropping_q && keep;
	assign left_e  = keep ? send_words_left_q : '0;
	assign wr_j    = act ? WORDS_W'(words - left_e) : '0;
	assign id_base = BA_W'(id_q) * BA_W'(STORE_BYTES);
	assign base    = id_base + BA_W'(prod_q);
	assign wpos_nx = (meta_q.wpos + 1'b1 == meta_q.qlen) ? '0 : LEN_W'(meta_q.wpos + 1'b1);
	assign rpos_nx = (meta_q.rpos + 1'b1 == meta_q.qlen) ? '0 : LEN_W'(meta_q.rpos + 1'b1);
	assign rd_mask = byte_mask(rd_j_q, meta_q.item_bytes);

	// lowest free slot among those a handle can reach
	always_comb begin
		free_any = 1'b0;
		new_slot = '0;
		for (int q = SCAN - 1; q >= 0; q--) begin
			if (!used_q[q]) begin
				free_any = 1'b1;
				new_slot = 3'(q);
			end
		end
	end
	assign new_base   = BA_W'(new_slot) * BA_W'(STORE_BYTES);
	assign create_bad = (len_q == '0) || (32'(len_q) > 32'(MAX_LENGTH))
		|| (isz_q > ISZ_W'(ITEM_LIMIT)) || (prod_q > PROD_W'(STORE_BYTES));

	// sweep mask: bytes of this row inside the region
	always_comb begin
		for (int b = 0; b < 8; b++)
			clr_mask[b] = (clr_addr_q + BA_W'(b) >= clr_lo_q)
				&& (clr_addr_q + BA_W'(b) < clr_hi_q);
	end

	// multiplier operands: size check for create, slot offset otherwise
	always_comb begin
		priority if (cmd_q == CMD_CREATE) begin
			mul_a = len_q;
			mul_b = isz_q;
		end else if (cmd_q == CMD_SEND) begin
			mul_a = meta_rd.wpos;
			mul_b = meta_rd.item_bytes;
		end else begin
			mul_a = meta_rd.rpos;
			mul_b = meta_rd.item_bytes;
		end
	end

	// descriptor memory: write port from the sequencer, registered read
	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[meta_wa] <= meta_wd;
		if (req.valid && req.ready)
			meta_rd <= meta_mem[QW'((QW+3)'(req.queue_id))];
	end

	// sequencer
	always_comb begin
		state_d           = state_q;
		emit              = 1'b0;
		res_d             = '0;
		res_d.status      = ST_OK;
		res_d.last        = 1'b1;
		meta_we           = 1'b0;
		meta_wa           = id_idx;
		meta_wd           = meta_q;
		used_d            = used_q;
		send_active_d     = send_active_q;
		send_dropping_d   = send_dropping_q;
		send_queue_d      = send_queue_q;
		send_words_left_d = send_words_left_q;
		rd_base_d         = rd_base_q;
		rd_j_d            = rd_j_q;
		clr_addr_d        = clr_addr_q;
		clr_lo_d          = clr_lo_q;
		clr_hi_d          = clr_hi_q;
		st_we             = 1'b0;
		st_waddr          = base + BA_W'({wr_j, 3'b000});
		st_wdata          = data_q;
		st_mask           = byte_mask(wr_j, meta_q.item_bytes);
		st_re             = 1'b0;
		st_raddr          = rd_base_q + BA_W'({rd_j_q, 3'b000});

		unique case (state_q)
			S_IDLE: begin
				if (req.valid)
					state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
					emit    = 1'b1;
					// anything but a further word of the same queue closes the send
					if (!keep) begin
						send_active_d     = 1'b0;
						send_dropping_d   = 1'b0;
						send_words_left_d = '0;
					end
					unique case (cmd_q)
						CMD_CREATE: begin
							if (create_bad || !free_any) begin
								res_d.status = ST_FAIL;
							end else begin
								used_d[new_slot] = 1'b1;
								meta_we          = 1'b1;
								meta_wa          = QW'((QW+3)'(new_slot));
								meta_wd          = '0;
								meta_wd.item_bytes = isz_q;
								meta_wd.qlen     = len_q;
								res_d.handle     = new_slot;
								clr_lo_d         = new_base;
								clr_hi_d         = new_base + BA_W'(STORE_BYTES);
								clr_addr_d       = {new_base[BA_W-1:3], 3'b000};
								state_d          = S_CLR;
							end
						end
						CMD_DELETE: begin
							if (!slot_ok) begin
								res_d.status = ST_FAIL;
							end else begin
								used_d[id_idx] = 1'b0;
								clr_lo_d       = id_base;
								clr_hi_d       = id_base + BA_W'(STORE_BYTES);
								clr_addr_d     = {id_base[BA_W-1:3], 3'b000};
								state_d        = S_CLR;
							end
						end
						CMD_SEND: begin
							if (drp) begin
								send_words_left_d = send_words_left_q - 1'b1;
								if (send_words_left_q == WORDS_W'(1))
									send_dropping_d = 1'b0;
								res_d.status = ST_SEND_FAIL;
							end else if (act) begin
								st_we             = !skip_q;
								send_words_left_d = send_words_left_q - 1'b1;
								if (send_words_left_q == WORDS_W'(1)) begin
									send_active_d = 1'b0;
									meta_we       = 1'b1;
									meta_wd.wpos  = wpos_nx;
									meta_wd.count = meta_q.count + 1'b1;
								end
							end else if (!slot_ok || full) begin
								if (slot_ok && words > WORDS_W'(1)) begin
									send_dropping_d   = 1'b1;
									send_queue_d      = id_q;
									send_words_left_d = words - 1'b1;
								end
								res_d.status = ST_SEND_FAIL;
							end else begin
								st_we             = !skip_q;
								send_queue_d      = id_q;
								send_words_left_d = words - 1'b1;
								if (words == WORDS_W'(1)) begin
									meta_we       = 1'b1;
									meta_wd.wpos  = wpos_nx;
									meta_wd.count = meta_q.count + 1'b1;
								end else begin
									send_active_d = 1'b1;
								end
							end
						end
						CMD_RECV, CMD_PEEK: begin
							if (!slot_ok || meta_q.count == '0) begin
								res_d.status = ST_READ_FAIL;
							end else if (skip_q) begin
								if (cmd_q == CMD_RECV) begin
									meta_we       = 1'b1;
									meta_wd.rpos  = rpos_nx;
									meta_wd.count = meta_q.count - 1'b1;
								end
							end else begin
								emit      = 1'b0;
								rd_j_d    = '0;
								rd_base_d = base;
								state_d   = S_RD;
							end
						end
						CMD_RESET: begin
							if (!slot_ok) begin
								res_d.status = ST_FAIL;
							end else begin
								meta_we       = 1'b1;
								meta_wd.rpos  = '0;
								meta_wd.wpos  = '0;
								meta_wd.count = '0;
							end
						end
						CMD_QUERY: begin
							if (!slot_ok) begin
								res_d.status = ST_FAIL;
							end else begin
								res_d.waiting = meta_q.count;
								res_d.free    = meta_q.qlen - meta_q.count;
							end
						end
						CMD_CLEAR: begin
							used_d     = '0;
							clr_lo_d   = '0;
							clr_hi_d   = BA_W'(TOTAL);
							clr_addr_d = '0;
							state_d    = S_CLR;
						end
						default: begin
							res_d.status = ST_FAIL;
						end
					endcase
				end
			end
			S_RD: begin
				st_re   = 1'b1;
				state_d = S_RDW;
			end
			S_RDW: begin
				if (out_free) begin
					emit = 1'b1;
					for (int k = 0; k < 8; k++)
						res_d.data[8*k +: 8] = rd_mask[k] ? st_rdata[8*k +: 8] : 8'h00;
					res_d.last = (rd_j_q + 1'b1 == words);
					if (res_d.last) begin
						state_d = S_IDLE;
						if (cmd_q == CMD_RECV) begin
							meta_we       = 1'b1;
							meta_wd.rpos  = rpos_nx;
							meta_wd.count = meta_q.count - 1'b1;
						end
					end else begin
						rd_j_d  = rd_j_q + 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_CLR: begin
				st_we      = 1'b1;
				st_waddr   = clr_addr_q;
				st_wdata   = '0;
				st_mask    = clr_mask;
				clr_addr_d = clr_addr_q + BA_W'(8);
				if (clr_addr_q + BA_W'(8) >= clr_hi_q)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			used_q            <= '0;
			send_active_q     <= 1'b0;
			send_dropping_q   <= 1'b0;
			send_queue_q      <= '0;
			send_words_left_q <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			state_q           <= state_d;
			used_q            <= used_d;
			send_active_q     <= send_active_d;
			send_dropping_q   <= send_dropping_d;
			send_queue_q      <= send_queue_d;
			send_words_left_q <= send_words_left_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q  <= req.cmd;
			id_q   <= req.queue_id;
			data_q <= req.data_word;
			skip_q <= req.skip_data;
			len_q  <= req.length_req;
			isz_q  <= req.item_bytes_req;
		end
		if (state_q == S_DEC) begin
			meta_q <= meta_rd;
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (emit)
			out_q <= res_d;
		rd_base_q  <= rd_base_d;
		rd_j_q     <= rd_j_d;
		clr_addr_q <= clr_addr_d;
		clr_lo_q   <= clr_lo_d;
		clr_hi_q   <= clr_hi_d;
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.handle_out    = out_q.handle;
	assign rsp.items_waiting = out_q.waiting;
	assign rsp.spaces_free   = out_q.free;
	assign rsp.data_out      = out_q.data;
	assign rsp.last          = out_q.last;

	mqf_store #(
		.BYTES  (TOTAL),
		.ADDR_W (BA_W)
	) u_store (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr (st_waddr),
		.wr_data (st_wdata),
		.wr_mask (st_mask),
		.rd_en   (st_re),
		.rd_addr (st_raddr),
		.rd_data (st_rdata)
	);

`ifndef NO_ASSERTIONS
	// an open send and a drop never coexist
	a_send_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(send_active_q && send_dropping_q))
		else $error("send open and dropping at once");

	// an open send or drop always has words left
	a_send_left: assert property (@(posedge clk) disable iff (!arst_n)
		(send_active_q || send_dropping_q) |-> (send_words_left_q != '0))
		else $error("open send with no words left");

	// no command is taken during a store sweep
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !req.ready)
		else $error("command taken during store sweep");

	// the read loop never runs past the item
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDW) |-> (rd_j_q < words))
		else $error("read word index past item end");
`endif

endmodule
